// ===== rtl/s256c_pkg.sv =====
// Shared types, constants and round tables of the SHA-256 block compressor.
`default_nettype none

package s256c_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned HASH_N  = 8;
	localparam int unsigned BLOCK_N = 16;
	localparam int unsigned ROUND_N = 64;

	localparam int unsigned HIDX_W = $clog2(HASH_N);
	localparam int unsigned WCNT_W = $clog2(BLOCK_N);
	localparam int unsigned RND_W  = $clog2(ROUND_N);

	localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HASH_N - 1);
	localparam logic [WCNT_W-1:0] WCNT_LAST = WCNT_W'(BLOCK_N - 1);
	localparam logic [RND_W-1:0]  RND_LAST  = RND_W'(ROUND_N - 1);

	localparam logic [WORD_W-1:0] IV [HASH_N] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] ROUND_K [ROUND_N] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              word_we;
		logic              reload_iv;
		logic              load_vars;
		logic              round_en;
		logic [RND_W-1:0]  round_idx;
		logic              add_cv;
		logic [HIDX_W-1:0] out_idx;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sha256_block_compressor_core.sv =====
// Top level of the SHA-256 block compressor: stream ports, controller and datapath.
//
// The core takes a 512-bit block as sixteen 32-bit big-endian words; tuser high on a word
// reloads the standard initial hash value and makes that word the first of a new block.
// After the sixteenth word it runs the 64 rounds, one per cycle on a single round unit,
// adds the result into the chaining value and sends the eight hash words, H0 first, with
// tlast on H7. Input is taken only while no block is in work, so the core does not take a
// new block before the last one is through: it collects the words, loads the working
// variables, runs the rounds, adds into the chaining value and sends the hash words.
// Without the flag, the next block chains on the updated value.
`default_nettype none

module sha256_block_compressor_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] message_word
	input  wire logic        s_axis_tuser,  // [0] new_message
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [31:0] hash_word, [34:32] hash_index, zero fill
	output logic             m_axis_tlast
);
	import s256c_pkg::*;

	cmd_t              cmd;
	logic [WORD_W-1:0] hash_word;

	s256c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_new    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	s256c_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_word   (s_axis_tdata),
		.hash_word (hash_word)
	);

	assign m_axis_tdata = {5'b0, cmd.out_idx, hash_word};
	assign m_axis_tlast = (cmd.out_idx == HIDX_LAST);

endmodule

`default_nettype wire

// ===== rtl/s256c_dp.sv =====
// Datapath: message schedule window, working variables, round logic and chaining value.
`default_nettype none

module s256c_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire s256c_pkg::cmd_t               cmd,
	input  wire logic [s256c_pkg::WORD_W-1:0]  in_word,
	output logic      [s256c_pkg::WORD_W-1:0]  hash_word
);
	import s256c_pkg::*;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
		rotr = (v >> n) | (v << (WORD_W - n));
	endfunction

	logic [WORD_W-1:0] w_q   [BLOCK_N];
	logic [WORD_W-1:0] v_q   [HASH_N];
	logic [WORD_W-1:0] cv_q  [HASH_N];
	logic [WORD_W-1:0] hkw_q;

	logic [WORD_W-1:0] s0, s1, new_w;
	logic [WORD_W-1:0] big_s0, big_s1, ch, maj, t1, t2;
	logic [RND_W-1:0]  next_idx;

	always_comb begin
		s0     = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1     = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		new_w  = w_q[0] + s0 + w_q[9] + s1;
		big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		// hkw_q already holds h + K[t] + W[t] for this round.
		t1     = hkw_q + big_s1 + ch;
		t2     = big_s0 + maj;
		next_idx = cmd.round_idx + RND_W'(1);
	end

	// Rolling window: w_q[0] is the schedule word of the current round.
	always_ff @(posedge clk) begin
		if (cmd.word_we || cmd.round_en) begin
			for (int i = 0; i < BLOCK_N - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLOCK_N-1] <= cmd.word_we ? in_word : new_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			for (int i = 0; i < HASH_N; i++) begin
				v_q[i] <= cv_q[i];
			end
			hkw_q <= cv_q[HASH_N-1] + ROUND_K[0] + w_q[0];
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			// The next round's h is the current g and its word sits in w_q[1].
			hkw_q  <= v_q[6] + ROUND_K[next_idx] + w_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_N; i++) begin
				cv_q[i] <= IV[i];
			end
		end else if (cmd.reload_iv) begin
			for (int i = 0; i < HASH_N; i++) begin
				cv_q[i] <= IV[i];
			end
		end else if (cmd.add_cv) begin
			for (int i = 0; i < HASH_N; i++) begin
				cv_q[i] <= cv_q[i] + v_q[i];
			end
		end
	end

	assign hash_word = cv_q[cmd.out_idx];

endmodule

`default_nettype wire

// ===== rtl/s256c_ctrl.sv =====
// Controller state machine: word collection, round sequencing and hash word output.
`default_nettype none

module s256c_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_new,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output s256c_pkg::cmd_t       cmd
);
	import s256c_pkg::*;

	state_t            state_q, state_d;
	logic [WCNT_W-1:0] wcnt_q, wcnt_d, wcnt_eff;
	logic [RND_W-1:0]  rnd_q, rnd_d;
	logic [HIDX_W-1:0] oidx_q, oidx_d;
	logic              in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wcnt_q  <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			wcnt_q  <= wcnt_d;
			rnd_q   <= rnd_d;
			oidx_q  <= oidx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		wcnt_d    = wcnt_q;
		rnd_d     = rnd_q;
		oidx_d    = oidx_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		in_acc    = 1'b0;
		// A new message restarts the block at word zero.
		wcnt_eff  = in_new ? '0 : wcnt_q;
		cmd       = '0;
		cmd.round_idx = rnd_q;
		cmd.out_idx   = oidx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				in_acc   = in_valid;
				if (in_valid) begin
					cmd.word_we   = 1'b1;
					cmd.reload_iv = in_new;
					wcnt_d        = wcnt_eff + WCNT_W'(1);
					if (wcnt_eff == WCNT_LAST) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_vars = 1'b1;
				rnd_d         = '0;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				rnd_d        = rnd_q + RND_W'(1);
				if (rnd_q == RND_LAST) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				cmd.add_cv = 1'b1;
				oidx_d     = '0;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					oidx_d = oidx_q + HIDX_W'(1);
					if (oidx_q == HIDX_LAST) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_block_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wcnt_eff == WCNT_LAST) |=> (state_q == ST_LOAD))
		else $error("sixteenth word did not start the rounds");

	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == RND_LAST) |=> (state_q == ST_FINAL))
		else $error("round sequence did not end after the last round");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while hash words are pending");

	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && oidx_q == HIDX_LAST) |=> (state_q == ST_IDLE && wcnt_q == '0))
		else $error("output run did not return to idle at word zero");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking stream testbench for the SHA-256 block compressor core.
`timescale 1ns / 100ps

module tb;

	import s256c_pkg::*;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} hash_word_t;

	// Tracks the chaining value and the partly collected block, and holds the
	// hash words that the core still owes.
	class sha256_chain_model;
		logic [31:0] cv [8];
		logic [31:0] window [16];
		logic [3:0]  count;
		hash_word_t  pending_hash [$];
		int          errors;

		function new();
			cv = H_INIT;
			count = 0;
			errors = 0;
		endfunction

		function logic [31:0] rotr(logic [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function int pending();
			return pending_hash.size();
		endfunction

		function void note_word(logic [31:0] word, logic first);
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] t1;
			logic [31:0] t2;
			logic [31:0] s0;
			logic [31:0] s1;
			hash_word_t  hw;
			if (first) begin
				cv = H_INIT;
				count = 0;
			end
			window[count] = word;
			count++;
			if (count != 0)
				return;
			for (int t = 0; t < 64; t++) begin
				if (t < 16) begin
					w[t] = window[t];
				end else begin
					s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
					s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
					w[t] = w[t-16] + s0 + w[t-7] + s1;
				end
			end
			v = cv;
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) begin
				cv[i] = cv[i] + v[i];
				hw.word = cv[i];
				hw.idx = 3'(i);
				hw.last = (i == 7);
				pending_hash.push_back(hw);
			end
		endfunction

		function void check_word(logic [39:0] data, logic last);
			hash_word_t exp_hw;
			if (pending_hash.size() == 0) begin
				$error("unexpected hash word %h", data[31:0]);
				errors++;
				return;
			end
			exp_hw = pending_hash.pop_front();
			if (data[31:0] !== exp_hw.word) begin
				$error("hash_word: expected %h, got %h", exp_hw.word, data[31:0]);
				errors++;
			end
			if (data[34:32] !== exp_hw.idx) begin
				$error("hash_index: expected %0d, got %0d", exp_hw.idx, data[34:32]);
				errors++;
			end
			if (last !== exp_hw.last) begin
				$error("last_word: expected %b, got %b", exp_hw.last, last);
				errors++;
			end
			if (data[39:35] !== 5'd0) begin
				$error("tdata fill: expected %h, got %h", 5'd0, data[39:35]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	sha256_chain_model hasher;
	int                words_sent;
	logic              tx_burst;
	logic              rx_burst;

	sha256_block_compressor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Starts at a falling edge and returns at the falling edge after acceptance.
	task automatic send_word(input logic [31:0] word, input logic first);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= first;
		do @(posedge clk); while (!s_axis_tready);
		hasher.note_word(word, first);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n;
		int blocks;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		arst_n = 1'b0;
		hasher = new();
		words_sent = 0;
		tx_burst = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A full block without the flag must hash from the reset chaining value.
		for (int i = 0; i < 16; i++) begin
			case (i % 4)
				0: send_word(32'h0000_0000, 1'b0);
				1: send_word(32'hffff_ffff, 1'b0);
				2: send_word(32'h8000_0000 >> i, 1'b0);
				default: send_word(32'h0000_0001 << i, 1'b0);
			endcase
		end
		// Hold off until the whole hash is back before going on.
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (hasher.pending() != 0);
		// Chain into a second block, then drop it with a flag in mid block.
		for (int i = 0; i < 4; i++)
			send_word(32'h5555_5555 ^ (32'hffff_ffff * (i % 2)), 1'b0);
		send_word(32'hffff_ffff, 1'b1);

		while (words_sent < 455) begin
			n = $urandom_range(0, 9);
			if (n < 8) begin
				blocks = $urandom_range(1, 3);
				for (int b = 0; b < blocks; b++)
					for (int i = 0; i < 16; i++)
						send_word(pick_word(), b == 0 && i == 0);
			end else if (n == 8) begin
				// A message that is abandoned part way through its block.
				n = $urandom_range(1, 15);
				for (int i = 0; i < n; i++)
					send_word(pick_word(), i == 0);
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_word(pick_word(), $urandom_range(0, 3) == 0);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (hasher.pending() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (hasher.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 11) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			hasher.check_word(m_axis_tdata, m_axis_tlast);
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/s256c_pkg.sv
rtl/s256c_dp.sv
rtl/s256c_ctrl.sv
rtl/sha256_block_compressor_core.sv
verif/tb.sv
